[src/sh24_pkg.sv]
package sh24_pkg;

  // SipHash initialization constants.
  localparam logic [63:0] SIP_INIT_A = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_INIT_B = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_INIT_C = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_INIT_D = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;
  localparam int unsigned LEN_SHIFT = 56;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;

  // Microcode addresses.
  typedef logic [2:0] upc_t;
  localparam upc_t UPC_IDLE    = 3'd0;
  localparam upc_t UPC_ABS_A   = 3'd1;
  localparam upc_t UPC_ABS_B   = 3'd2;
  localparam upc_t UPC_FIN_0   = 3'd3;
  localparam upc_t UPC_FIN_1   = 3'd4;
  localparam upc_t UPC_FIN_2   = 3'd5;
  localparam upc_t UPC_FIN_3   = 3'd6;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_ABSORB_END,
    JMP_EMIT
  } jmp_t;

  typedef struct packed {
    logic xor_m_v3;
    logic round_en;
    logic xor_m_v0;
    logic xor_ff;
    logic emit;
    jmp_t jmp;
    upc_t target;
  } ucode_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    w = '{xor_m_v3: 1'b0, round_en: 1'b0, xor_m_v0: 1'b0, xor_ff: 1'b0,
          emit: 1'b0, jmp: JMP_NEXT, target: UPC_IDLE};
    case (addr)
      UPC_IDLE: begin
        w.jmp    = JMP_WAIT_IN;
        w.target = UPC_ABS_A;
      end
      UPC_ABS_A: begin
        w.xor_m_v3 = 1'b1;
        w.round_en = 1'b1;
      end
      UPC_ABS_B: begin
        w.round_en = 1'b1;
        w.xor_m_v0 = 1'b1;
        w.jmp      = JMP_ABSORB_END;
        w.target   = UPC_FIN_0;
      end
      UPC_FIN_0: begin
        w.xor_ff   = 1'b1;
        w.round_en = 1'b1;
      end
      UPC_FIN_1, UPC_FIN_2: begin
        w.round_en = 1'b1;
      end
      UPC_FIN_3: begin
        w.round_en = 1'b1;
        w.emit     = 1'b1;
        w.jmp      = JMP_EMIT;
        w.target   = UPC_IDLE;
      end
      default: begin
        w.jmp    = JMP_EMIT;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1;
    t.v1 = rotl(t.v1, 13) ^ t.v0;
    t.v0 = rotl(t.v0, 32);
    t.v2 = t.v2 + t.v3;
    t.v3 = rotl(t.v3, 16) ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rotl(t.v3, 21) ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rotl(t.v1, 17) ^ t.v2;
    t.v2 = rotl(t.v2, 32);
    return t;
  endfunction

endpackage

[src/siphash_2_4_keyed_hash.sv]
// SipHash-2-4 keyed hash. Load the two key halves through the cfg port, then
// send the message as little-endian 64-bit words, the last one flagged with
// in_last and carrying 0 to 8 valid bytes. One 64-bit digest request comes out
// per message. A small microcode program runs one SipRound per cycle through a
// single round datapath: a word that is not last is accepted and then takes
// two rounds, a short last word adds four finalization rounds, and a full last
// word adds an extra length block of two rounds before those four. A new word
// is taken only between programs, but a finished digest may wait in the output
// register while the next message goes in; the final round stalls only if the
// previous digest has not been taken yet.
module siphash_2_4_keyed_hash
  import sh24_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest
);

  logic [63:0] key_low_r, key_high_r;
  upc_t        upc_r, upc_nxt;
  sip_state_t  v_r, v_nxt;
  logic [63:0] m_r, m_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        mid_r, mid_nxt;
  logic        final_r, final_nxt;
  logic        tail_pend_r, tail_pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] digest_r, digest_nxt;

  ucode_t      uw;
  sip_state_t  rnd_in, rnd_out, v_start;
  logic        in_acc, hold;
  logic [3:0]  cnt_clamp;
  logic [7:0]  len_base, len_sum;
  logic [63:0] tail_word;

  assign cfg_ready  = 1'b1;
  assign uw         = ucode_rom(upc_r);
  assign in_ready   = (uw.jmp == JMP_WAIT_IN);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_digest = digest_r;

  // The final round waits while the previous digest is still unread.
  assign hold = uw.emit && out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Length bookkeeping and tail block for the accepted word.
  always_comb begin
    cnt_clamp = in_byte_count[3] ? 4'd8 : in_byte_count;
    len_base  = mid_r ? len_r : 8'd0;
    len_sum   = len_base + (in_last ? {4'd0, cnt_clamp} : 8'd8);
    for (int i = 0; i < 8; i++) begin
      tail_word[8*i +: 8] = (4'(i) < cnt_clamp) ? in_data_word[8*i +: 8] : 8'h00;
    end
    v_start = mid_r ? v_r :
              sip_state_t'{v0: SIP_INIT_A ^ key_low_r, v1: SIP_INIT_B ^ key_high_r,
                           v2: SIP_INIT_C ^ key_low_r, v3: SIP_INIT_D ^ key_high_r};
  end

  always_comb begin
    rnd_in    = v_r;
    rnd_in.v3 = v_r.v3 ^ (uw.xor_m_v3 ? m_r : 64'd0);
    rnd_in.v2 = v_r.v2 ^ (uw.xor_ff ? SIP_FINAL_XOR : 64'd0);
    rnd_out   = sip_round(rnd_in);
    rnd_out.v0 = rnd_out.v0 ^ (uw.xor_m_v0 ? m_r : 64'd0);
  end

  always_comb begin
    upc_nxt       = upc_r;
    v_nxt         = v_r;
    m_nxt         = m_r;
    len_nxt       = len_r;
    mid_nxt       = mid_r;
    final_nxt     = final_r;
    tail_pend_nxt = tail_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    digest_nxt    = digest_r;

    if (!hold) begin
      if (uw.round_en) begin
        v_nxt = rnd_out;
      end
      if (uw.emit) begin
        out_valid_nxt = 1'b1;
        digest_nxt    = rnd_out.v0 ^ rnd_out.v1 ^ rnd_out.v2 ^ rnd_out.v3;
        mid_nxt       = 1'b0;
        len_nxt       = '0;
      end
      case (uw.jmp)
        JMP_NEXT: begin
          upc_nxt = upc_r + 3'd1;
        end
        JMP_WAIT_IN: begin
          if (in_acc) begin
            upc_nxt = uw.target;
            v_nxt   = v_start;
            len_nxt = len_sum;
            mid_nxt = 1'b1;
            if (in_last && (cnt_clamp != 4'd8)) begin
              m_nxt         = tail_word | ({56'd0, len_sum} << LEN_SHIFT);
              final_nxt     = 1'b1;
              tail_pend_nxt = 1'b0;
            end else begin
              m_nxt         = in_data_word;
              final_nxt     = 1'b0;
              tail_pend_nxt = in_last;
            end
          end
        end
        JMP_ABSORB_END: begin
          if (final_r) begin
            upc_nxt = uw.target;
          end else if (tail_pend_r) begin
            // A full last word is followed by a block holding only the length.
            upc_nxt       = UPC_ABS_A;
            m_nxt         = {56'd0, len_r} << LEN_SHIFT;
            final_nxt     = 1'b1;
            tail_pend_nxt = 1'b0;
          end else begin
            upc_nxt = UPC_IDLE;
          end
        end
        JMP_EMIT: begin
          upc_nxt = uw.target;
        end
        default: begin
          upc_nxt = UPC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_IDLE;
      len_r       <= '0;
      mid_r       <= 1'b0;
      final_r     <= 1'b0;
      tail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      len_r       <= len_nxt;
      mid_r       <= mid_nxt;
      final_r     <= final_nxt;
      tail_pend_r <= tail_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    m_r      <= m_nxt;
    digest_r <= digest_nxt;
  end

endmodule

[src/sh24_checker.sv]
module sh24_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest
);

  // A digest request that is not taken stays up with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest))
    else $error("digest request dropped or changed while stalled");

  // After reset the block is empty and ready for a message word.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A new digest appears only as the program returns to wait for input.
  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $rose(in_ready))
    else $error("digest raised without the sequencer returning to idle");

  // A last word runs at least the two absorb rounds and four final rounds.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=>
      !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
      ##1 !in_ready)
    else $error("input taken before the finalization rounds completed");

endmodule

bind siphash_2_4_keyed_hash sh24_checker u_sh24_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sh24_pkg::*;

  // Writes to these indexes must leave both key halves alone.
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int WORD_TARGET = 1250;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_DIGESTS = 60;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [63:0] value;
    logic [63:0] word;
    logic [3:0]  count;
    logic        last_flag;
    logic        known;
    logic [63:0] digest;
  } plan_row_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } mix_state_t;

  localparam int PLAN_LEN = 21;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  // Keys 00..0f give the published digests for the empty message and for the
  // fifteen-byte message 00..0e.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'h0123456789abcdef, 4'd0, 1'b1, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_LOW, 64'h0706050403020100, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG, CFG_SPARE_2, ONES, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG, CFG_SPARE_3, 64'h5a5a_c3c3_0ff0_a5a5, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'd0, 4'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'h0706050403020100, 4'd8, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'hff0e0d0c0b0a0908, 4'd7, 1'b1, 1'b1,
      64'ha129ca6149be45e5},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, ONES, 4'd8, 1'b1, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, ONES, 4'd15, 1'b1, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'h1122334455667788, 4'd3, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'h8877665544332211, 4'd9, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'hfedcba9876543210, 4'd1, 1'b1, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_LOW, ONES, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_HIGH, ONES, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, ONES, 4'd7, 1'b1, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'd0, 4'd8, 1'b1, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_LOW, 64'd0, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_CFG, CFG_KEY_HIGH, 64'd0, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, CFG_KEY_LOW, 64'd0, 64'h8000000000000001, 4'd4, 1'b1, 1'b0, 64'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest;

  logic [63:0] key_low_shadow;
  logic [63:0] key_high_shadow;
  mix_state_t  hash_state;
  logic [7:0]  byte_total;
  logic        in_message;
  logic [63:0] expected_digests [$];
  int          error_count;
  int          digests_taken;
  int          words_sent;
  int          burst_left;

  siphash_2_4_keyed_hash u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_digest   (out_digest)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("siphash_2_4_keyed_hash verification failed");
    $finish;
  end

  function automatic logic [63:0] rotate_left(logic [63:0] x, int r);
    logic [127:0] wide;
    wide = {x, x} << r;
    return wide[127:64];
  endfunction

  function automatic mix_state_t mix_round(mix_state_t s);
    s.v0 = s.v0 + s.v1;
    s.v1 = rotate_left(s.v1, 13) ^ s.v0;
    s.v0 = rotate_left(s.v0, 32);
    s.v2 = s.v2 + s.v3;
    s.v3 = rotate_left(s.v3, 16) ^ s.v2;
    s.v0 = s.v0 + s.v3;
    s.v3 = rotate_left(s.v3, 21) ^ s.v0;
    s.v2 = s.v2 + s.v1;
    s.v1 = rotate_left(s.v1, 17) ^ s.v2;
    s.v2 = rotate_left(s.v2, 32);
    return s;
  endfunction

  function automatic mix_state_t absorb_block(mix_state_t s, logic [63:0] m);
    s.v3 = s.v3 ^ m;
    s = mix_round(mix_round(s));
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

  // Advances the running hash by one accepted word; returns 1 with the digest
  // when the word closes a message.
  function automatic logic advance_hash(logic [63:0] word, logic [3:0] count,
                                        logic last_flag, output logic [63:0] digest);
    logic [3:0]  used;
    logic [63:0] tail;
    digest = '0;
    if (!in_message) begin
      hash_state.v0 = SIP_INIT_A ^ key_low_shadow;
      hash_state.v1 = SIP_INIT_B ^ key_high_shadow;
      hash_state.v2 = SIP_INIT_C ^ key_low_shadow;
      hash_state.v3 = SIP_INIT_D ^ key_high_shadow;
      byte_total = '0;
    end
    if (!last_flag) begin
      // Any word before the last one counts as a full block.
      hash_state = absorb_block(hash_state, word);
      byte_total = byte_total + 8'd8;
      in_message = 1'b1;
      return 1'b0;
    end
    used = (count > 4'd8) ? 4'd8 : count;
    tail = '0;
    if (used == 4'd8) begin
      hash_state = absorb_block(hash_state, word);
    end else if (used != 4'd0) begin
      tail = word & ((64'd1 << (8 * used)) - 64'd1);
    end
    byte_total = byte_total + {4'd0, used};
    hash_state = absorb_block(hash_state, tail | ({56'd0, byte_total} << LEN_SHIFT));
    hash_state.v2 = hash_state.v2 ^ SIP_FINAL_XOR;
    repeat (4) hash_state = mix_round(hash_state);
    digest = hash_state.v0 ^ hash_state.v1 ^ hash_state.v2 ^ hash_state.v3;
    in_message = 1'b0;
    byte_total = '0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (error_count < 40) begin
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                           input logic last_flag, input logic known,
                           input logic [63:0] known_digest);
    int          gap;
    logic [63:0] digest;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_byte_count <= count;
    in_last       <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (advance_hash(word, count, last_flag, digest)) begin
      expected_digests.push_back(known ? known_digest : digest);
    end
    words_sent++;
    burst_left--;
  endtask

  // Lets the block drain so the key registers can be written while it is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == CFG_KEY_LOW) begin
      key_low_shadow = value;
    end else if (index == CFG_KEY_HIGH) begin
      key_high_shadow = value;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: out_ready is drawn at random with a ready rate that changes from phase
  // to phase, with one long hold-off so the output register fills and the input side backs up.
  initial begin
    int  ready_pct;
    int  phase_left;
    logic hold_done;
    ready_pct = 100;
    phase_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && digests_taken >= HOLD_AFTER_DIGESTS) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 45;
          default: ready_pct = 15;
        endcase
        phase_left = 64;
      end
      phase_left--;
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_valid && out_ready) begin
      digests_taken++;
      if (expected_digests.size() == 0) begin
        note_mismatch("digest with no request outstanding", out_digest, '0);
      end else begin
        want = expected_digests.pop_front();
        if (out_digest !== want) begin
          note_mismatch("digest mismatch", out_digest, want);
        end
      end
    end
  end

  initial begin
    int         msg_count;
    int         body_words;
    logic [3:0] count;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_KEY_LOW;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_data_word  <= '0;
    in_byte_count <= '0;
    in_last       <= 1'b0;
    key_low_shadow  = '0;
    key_high_shadow = '0;
    hash_state      = '0;
    byte_total      = '0;
    in_message      = 1'b0;
    error_count     = 0;
    digests_taken   = 0;
    words_sent      = 0;
    burst_left      = 0;
    msg_count       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        write_register(PLAN[i].index, PLAN[i].value);
      end else begin
        send_word(PLAN[i].word, PLAN[i].count, PLAN[i].last_flag, PLAN[i].known,
                  PLAN[i].digest);
      end
    end

    // Random messages, mostly short, now and then long enough to wrap the
    // byte length past 255. Keys change between groups of messages.
    while (words_sent < WORD_TARGET) begin
      if (msg_count % 10 == 0) begin
        settle();
        if ($urandom_range(0, 3) == 0) begin
          write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                         {$urandom, $urandom});
        end
        write_register(CFG_KEY_LOW, pick_key());
        write_register(CFG_KEY_HIGH, pick_key());
      end
      body_words = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40)
                                                : $urandom_range(0, 4);
      for (int w = 0; w < body_words; w++) begin
        count = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        send_word({$urandom, $urandom}, count, 1'b0, 1'b0, '0);
      end
      count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      send_word({$urandom, $urandom}, count, 1'b1, 1'b0, '0);
      msg_count++;
    end

    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("siphash_2_4_keyed_hash verification clean");
    end else begin
      $display("siphash_2_4_keyed_hash verification failed");
    end
    $finish;
  end

endmodule
